/* sv/lvm_pkg.sv */
// shared constants and types for the look-at view matrix block
package lvm_pkg;

  localparam int FracBitsDef = 16;
  localparam int CoordW      = 32;
  localparam int NormW       = 31;
  localparam int NormTop     = 30;
  localparam int SqrtSteps   = 32;
  localparam int SumW        = 64;
  localparam int LenW        = 32;

  localparam logic signed [CoordW-1:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] SatMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ROW_X = 2'd0,
    ROW_Y = 2'd1,
    ROW_Z = 2'd2
  } row_e;

endpackage

/* sv/lvm_norm.sv */
// pipelined vector normalizer: block scaling, square root and per-lane division
module lvm_norm import lvm_pkg::*; #(
  parameter int IW       = 33,
  parameter int SW       = 8,
  parameter int FracBits = FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [2:0][IW-1:0]             vec_i,
  input  logic [SW-1:0]                  side_i,
  output logic                           valid_o,
  output logic                           zero_o,
  output logic [2:0][FracBits+1:0]       n_o,
  output logic [SW-1:0]                  side_o
);

  localparam int PW = $clog2(IW);
  localparam int NW = NormW + 1 + FracBits;
  localparam int QW = FracBits + 1;
  localparam int OW = FracBits + 2;

  typedef struct packed {
    logic          zero;
    logic [2:0]    neg;
    logic [SW-1:0] side;
  } ctl_t;

  // stage 0: magnitudes
  logic [2:0][IW-1:0] mag0_d, mag0_q;
  logic [2:0]         neg0_d;
  ctl_t               c0_q;
  logic               v0_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg0_d[i] = vec_i[i][IW-1];
      mag0_d[i] = neg0_d[i] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
  end

  // stage 1: leading one of the or of all magnitudes
  logic [IW-1:0]      orv;
  logic [PW-1:0]      pos1_d, pos1_q;
  logic [2:0][IW-1:0] mag1_q;
  ctl_t               c1_q;
  logic               v1_q;

  always_comb begin
    orv    = mag0_q[0] | mag0_q[1] | mag0_q[2];
    pos1_d = '0;
    for (int i = 0; i < IW; i++) begin
      if (orv[i]) pos1_d = PW'(i);
    end
  end

  // stage 2: common shift into [2^30, 2^31)
  logic [2:0][IW-1:0]    rs, ls;
  logic [2:0][NormW-1:0] m2_d, m2_q;
  ctl_t                  c2_q;
  logic                  v2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = mag1_q[i] >> (pos1_q - PW'(NormTop));
      ls[i] = mag1_q[i] << (PW'(NormTop) - pos1_q);
      if (pos1_q > PW'(NormTop)) begin
        m2_d[i] = rs[i][NormW-1:0];
      end else begin
        m2_d[i] = ls[i][NormW-1:0];
      end
    end
  end

  // stage 3: squares, stage 4: sum
  logic [2:0][2*NormW-1:0] sq3_q;
  logic [2:0][NormW-1:0]   m3_q, m4_q;
  logic [SumW-1:0]         sum4_q;
  ctl_t                    c3_q, c4_q;
  logic                    v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag0_q    <= mag0_d;
      c0_q.zero <= 1'b0;
      c0_q.neg  <= neg0_d;
      c0_q.side <= side_i;
      mag1_q    <= mag0_q;
      pos1_q    <= pos1_d;
      c1_q      <= '{zero: (orv == '0), neg: c0_q.neg, side: c0_q.side};
      m2_q      <= m2_d;
      c2_q      <= c1_q;
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= m2_q[i] * m2_q[i];
      end
      m3_q      <= m2_q;
      c3_q      <= c2_q;
      sum4_q    <= SumW'(sq3_q[0]) + SumW'(sq3_q[1]) + SumW'(sq3_q[2]);
      m4_q      <= m3_q;
      c4_q      <= c3_q;
    end
  end

  // square root, one result bit per stage
  logic [SumW-1:0]       sx_q [SqrtSteps];
  logic [SumW-1:0]       sr_q [SqrtSteps];
  logic [2:0][NormW-1:0] sm_q [SqrtSteps];
  ctl_t                  sc_q [SqrtSteps];
  logic                  sv_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [SumW-1:0] Bit = SumW'(1) << (2 * (SqrtSteps - 1 - k));
    logic [SumW-1:0]       xin, rin, trial;
    logic [2:0][NormW-1:0] min;
    ctl_t                  cin;
    logic                  vin;

    if (k == 0) begin : g_first
      assign xin = sum4_q;
      assign rin = '0;
      assign min = m4_q;
      assign cin = c4_q;
      assign vin = v4_q;
    end else begin : g_next
      assign xin = sx_q[k-1];
      assign rin = sr_q[k-1];
      assign min = sm_q[k-1];
      assign cin = sc_q[k-1];
      assign vin = sv_q[k-1];
    end

    assign trial = rin + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (en_i) begin
        sv_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (xin >= trial) begin
          sx_q[k] <= xin - trial;
          sr_q[k] <= (rin >> 1) + Bit;
        end else begin
          sx_q[k] <= xin;
          sr_q[k] <= rin >> 1;
        end
        sm_q[k] <= min;
        sc_q[k] <= cin;
      end
    end
  end

  // stage 5: rounded numerators
  logic [LenW-1:0]    len;
  logic [2:0][NW-1:0] num5_q;
  logic [LenW-1:0]    l5_q;
  ctl_t               c5_q;
  logic               v5_q;

  assign len = sr_q[SqrtSteps-1][LenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= sv_q[SqrtSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        num5_q[i] <= (NW'(sm_q[SqrtSteps-1][i]) << FracBits) + NW'(len >> 1);
      end
      l5_q <= len;
      c5_q <= sc_q[SqrtSteps-1];
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  logic [2:0][NW-1:0] dr_q [QW];
  logic [2:0][QW-1:0] dq_q [QW];
  logic [LenW-1:0]    dl_q [QW];
  ctl_t               dc_q [QW];
  logic               dv_q [QW];

  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int Sh = FracBits - t;
    logic [2:0][NW-1:0] rin;
    logic [2:0][QW-1:0] qin;
    logic [LenW-1:0]    lin;
    logic [NW-1:0]      dsh;
    ctl_t               cin;
    logic               vin;

    if (t == 0) begin : g_first
      assign rin = num5_q;
      assign qin = '0;
      assign lin = l5_q;
      assign cin = c5_q;
      assign vin = v5_q;
    end else begin : g_next
      assign rin = dr_q[t-1];
      assign qin = dq_q[t-1];
      assign lin = dl_q[t-1];
      assign cin = dc_q[t-1];
      assign vin = dv_q[t-1];
    end

    assign dsh = NW'(lin) << Sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[t] <= 1'b0;
      end else if (en_i) begin
        dv_q[t] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (rin[i] >= dsh) begin
            dr_q[t][i] <= rin[i] - dsh;
            dq_q[t][i] <= qin[i] | (QW'(1) << Sh);
          end else begin
            dr_q[t][i] <= rin[i];
            dq_q[t][i] <= qin[i];
          end
        end
        dl_q[t] <= lin;
        dc_q[t] <= cin;
      end
    end
  end

  // output: reapply signs
  logic [2:0][OW-1:0] n_q;
  ctl_t               co_q;
  logic               vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= dc_q[QW-1].neg[i] ? -OW'(dq_q[QW-1][i]) : OW'(dq_q[QW-1][i]);
      end
      co_q <= dc_q[QW-1];
    end
  end

  assign valid_o = vo_q;
  assign zero_o  = co_q.zero;
  assign n_o     = n_q;
  assign side_o  = co_q.side;

endmodule

/* sv/lookat_view_matrix_top.sv */
// look-at view matrix: axis pipeline, translation dot products and row output
// rows 0, 1 and 2 leave the three-row output register in order, each advancing when out_ready_i
//   is high; a new input is taken only while that register is empty or its last row is being taken
// the pipeline is fully registered and stalls as a whole while the output register is busy
// reset: asynchronous, active low; clears all valid bits, no clearing pass
module lookat_view_matrix_top import lvm_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] eye_x_i,
  input  logic signed [CoordW-1:0] eye_y_i,
  input  logic signed [CoordW-1:0] eye_z_i,
  input  logic signed [CoordW-1:0] target_x_i,
  input  logic signed [CoordW-1:0] target_y_i,
  input  logic signed [CoordW-1:0] target_z_i,
  input  logic signed [CoordW-1:0] up_x_i,
  input  logic signed [CoordW-1:0] up_y_i,
  input  logic signed [CoordW-1:0] up_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               row_index_o,
  output logic signed [CoordW-1:0] entry_c0_o,
  output logic signed [CoordW-1:0] entry_c1_o,
  output logic signed [CoordW-1:0] entry_c2_o,
  output logic signed [CoordW-1:0] entry_c3_o,
  output logic                     last_row_o,
  output logic                     degenerate_o
);

  localparam int F   = FRAC_BITS;
  localparam int DW  = CoordW + 1;
  localparam int ZW  = F + 2;
  localparam int CPW = CoordW + ZW;
  localparam int CW  = CPW + 1;
  localparam int YPW = 2 * ZW;
  localparam int YDW = YPW + 1;
  localparam int AW  = F + 3;
  localparam int DPW = AW + CoordW;
  localparam int DSW = DPW + 2;
  localparam int RW  = DSW - F;
  localparam int TW  = RW + 1;

  typedef struct packed {
    logic [2:0][CoordW-1:0] eye;
    logic [2:0][CoordW-1:0] up;
  } side1_t;

  typedef struct packed {
    logic                   dg;
    logic [2:0][CoordW-1:0] eye;
    logic [2:0][ZW-1:0]     z;
  } side2_t;

  logic en;
  logic ser_v_q;
  row_e cnt_q;

  assign en         = !ser_v_q || (out_ready_i && (cnt_q == ROW_Z));
  assign in_ready_o = en;

  // stage a: look direction
  logic [2:0][DW-1:0] d_q;
  side1_t             sa_q;
  logic               va_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0]  <= DW'(target_x_i) - DW'(eye_x_i);
      d_q[1]  <= DW'(target_y_i) - DW'(eye_y_i);
      d_q[2]  <= DW'(target_z_i) - DW'(eye_z_i);
      sa_q.eye <= {eye_x_i, eye_y_i, eye_z_i};
      sa_q.up  <= {up_x_i, up_y_i, up_z_i};
    end
  end

  // z axis
  logic               v1;
  logic               zero1;
  logic [2:0][ZW-1:0] zn;
  side1_t             s1;

  lvm_norm #(.IW(DW), .SW($bits(side1_t)), .FracBits(F)) u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_q),
    .vec_i   ({d_q[2], d_q[1], d_q[0]}),
    .side_i  (sa_q),
    .valid_o (v1),
    .zero_o  (zero1),
    .n_o     (zn),
    .side_o  (s1)
  );

  // up cross z: products, then differences
  logic signed [CPW-1:0] p_d [6];
  logic signed [CPW-1:0] p_q [6];
  logic signed [ZW-1:0]  z0, z1, z2;
  logic signed [CoordW-1:0] u0, u1, u2;
  side2_t                sc1_q, sc2_q;
  logic [2:0][CW-1:0]    c2_q;
  logic                  vc1_q, vc2_q;

  assign z0 = zn[0];
  assign z1 = zn[1];
  assign z2 = zn[2];
  assign u0 = s1.up[2];
  assign u1 = s1.up[1];
  assign u2 = s1.up[0];

  always_comb begin
    p_d[0] = u1 * z2;
    p_d[1] = u2 * z1;
    p_d[2] = u2 * z0;
    p_d[3] = u0 * z2;
    p_d[4] = u0 * z1;
    p_d[5] = u1 * z0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q       <= p_d;
      sc1_q.dg  <= zero1;
      sc1_q.eye <= s1.eye;
      sc1_q.z   <= zn;
      for (int i = 0; i < 3; i++) begin
        c2_q[i] <= CW'(p_q[2*i]) - CW'(p_q[2*i+1]);
      end
      sc2_q <= sc1_q;
    end
  end

  // x axis
  logic               v2;
  logic               zero2;
  logic [2:0][ZW-1:0] xn;
  side2_t             s2;

  lvm_norm #(.IW(CW), .SW($bits(side2_t)), .FracBits(F)) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc2_q),
    .vec_i   ({c2_q[2], c2_q[1], c2_q[0]}),
    .side_i  (sc2_q),
    .valid_o (v2),
    .zero_o  (zero2),
    .n_o     (xn),
    .side_o  (s2)
  );

  // y axis = z cross x, rounded
  logic signed [ZW-1:0]  xz0, xz1, xz2, xx0, xx1, xx2;
  logic signed [YPW-1:0] q_d [6];
  logic signed [YPW-1:0] q_q [6];
  logic signed [YDW-1:0] yd [3];
  logic [2:0][YDW-1:0]   ymag_q;
  logic [2:0][YDW-1:0]   yr;
  logic [2:0]            yneg_q;
  logic [2:0][AW-1:0]    y_q;
  logic [2:0][ZW-1:0]    ax1_x_q, ax2_x_q, ax3_x_q, ax1_z_q, ax2_z_q, ax3_z_q;
  logic [2:0][CoordW-1:0] e1_q, e2_q, e3_q;
  logic                  dg1_q, dg2_q, dg3_q;
  logic                  vy1_q, vy2_q, vy3_q;

  assign xz0 = s2.z[0];
  assign xz1 = s2.z[1];
  assign xz2 = s2.z[2];
  assign xx0 = xn[0];
  assign xx1 = xn[1];
  assign xx2 = xn[2];

  always_comb begin
    q_d[0] = xz1 * xx2;
    q_d[1] = xz2 * xx1;
    q_d[2] = xz2 * xx0;
    q_d[3] = xz0 * xx2;
    q_d[4] = xz0 * xx1;
    q_d[5] = xz1 * xx0;
    for (int i = 0; i < 3; i++) begin
      yd[i] = YDW'(q_q[2*i]) - YDW'(q_q[2*i+1]);
      yr[i] = (ymag_q[i] + (YDW'(1) << (F - 1))) >> F;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q     <= q_d;
      ax1_x_q <= xn;
      ax1_z_q <= s2.z;
      e1_q    <= s2.eye;
      dg1_q   <= s2.dg | zero2;
      for (int i = 0; i < 3; i++) begin
        yneg_q[i] <= yd[i][YDW-1];
        ymag_q[i] <= yd[i][YDW-1] ? YDW'(-yd[i]) : YDW'(yd[i]);
      end
      ax2_x_q <= ax1_x_q;
      ax2_z_q <= ax1_z_q;
      e2_q    <= e1_q;
      dg2_q   <= dg1_q;
      for (int i = 0; i < 3; i++) begin
        y_q[i] <= yneg_q[i] ? -AW'(yr[i][AW-1:0]) : AW'(yr[i][AW-1:0]);
      end
      ax3_x_q <= ax2_x_q;
      ax3_z_q <= ax2_z_q;
      e3_q    <= e2_q;
      dg3_q   <= dg2_q;
    end
  end

  // translation column: products, then sums
  // axis lanes run x to z from index 0, the packed eye runs x to z from index 2
  logic signed [AW-1:0]     ax [3][3];
  logic signed [CoordW-1:0] ev [3];
  logic signed [DPW-1:0]    dp_q [3][3];
  logic [2:0][2:0][AW-1:0]  axd1_q, axd2_q;
  logic signed [DSW-1:0]    ds [3];
  logic [2:0][DSW-1:0]      dmag_q;
  logic [2:0]               dneg_q;
  logic                     dgd1_q, dgd2_q;
  logic                     vd1_q, vd2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[0][i] = AW'(signed'(ax3_x_q[i]));
      ax[1][i] = y_q[i];
      ax[2][i] = AW'(signed'(ax3_z_q[i]));
      ev[i]    = e3_q[2-i];
    end
    for (int r = 0; r < 3; r++) begin
      ds[r] = DSW'(dp_q[r][0]) + DSW'(dp_q[r][1]) + DSW'(dp_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          dp_q[r][i]   <= DPW'(ax[r][i]) * DPW'(ev[i]);
          axd1_q[r][i] <= ax[r][i];
        end
      end
      dgd1_q <= dg3_q;
      for (int r = 0; r < 3; r++) begin
        dneg_q[r] <= ds[r][DSW-1];
        dmag_q[r] <= ds[r][DSW-1] ? DSW'(-ds[r]) : DSW'(ds[r]);
      end
      axd2_q <= axd1_q;
      dgd2_q <= dgd1_q;
    end
  end

  // round, negate, saturate; load the row output register
  logic [2:0][DSW-1:0]         dr;
  logic signed [2:0][TW-1:0]   tv;
  logic [2:0][3:0][CoordW-1:0] ent_d, ent_q;
  logic                        dg_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dr[r] = (dmag_q[r] + (DSW'(1) << (F - 1))) >> F;
      tv[r] = dneg_q[r] ? TW'(dr[r][RW-1:0]) : -TW'(dr[r][RW-1:0]);
      for (int i = 0; i < 3; i++) begin
        ent_d[r][i] = CoordW'(signed'(axd2_q[r][i]));
      end
      if ($signed(tv[r]) > $signed(TW'(SatMax))) begin
        ent_d[r][3] = SatMax;
      end else if ($signed(tv[r]) < $signed(TW'(SatMin))) begin
        ent_d[r][3] = SatMin;
      end else begin
        ent_d[r][3] = tv[r][CoordW-1:0];
      end
      if (dgd2_q) begin
        ent_d[r] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vc1_q   <= 1'b0;
      vc2_q   <= 1'b0;
      vy1_q   <= 1'b0;
      vy2_q   <= 1'b0;
      vy3_q   <= 1'b0;
      vd1_q   <= 1'b0;
      vd2_q   <= 1'b0;
      ser_v_q <= 1'b0;
      cnt_q   <= ROW_X;
    end else if (en) begin
      va_q    <= in_valid_i;
      vc1_q   <= v1;
      vc2_q   <= vc1_q;
      vy1_q   <= v2;
      vy2_q   <= vy1_q;
      vy3_q   <= vy2_q;
      vd1_q   <= vy3_q;
      vd2_q   <= vd1_q;
      ser_v_q <= vd2_q;
      cnt_q   <= ROW_X;
    end else if (out_ready_i) begin
      unique case (cnt_q)
        ROW_X:   cnt_q <= ROW_Y;
        ROW_Y:   cnt_q <= ROW_Z;
        default: cnt_q <= ROW_X;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q <= ent_d;
      dg_q  <= dgd2_q;
    end
  end

  always_comb begin
    entry_c0_o = '0;
    entry_c1_o = '0;
    entry_c2_o = '0;
    entry_c3_o = '0;
    unique case (cnt_q)
      ROW_X: begin
        entry_c0_o = ent_q[0][0];
        entry_c1_o = ent_q[0][1];
        entry_c2_o = ent_q[0][2];
        entry_c3_o = ent_q[0][3];
      end
      ROW_Y: begin
        entry_c0_o = ent_q[1][0];
        entry_c1_o = ent_q[1][1];
        entry_c2_o = ent_q[1][2];
        entry_c3_o = ent_q[1][3];
      end
      default: begin
        entry_c0_o = ent_q[2][0];
        entry_c1_o = ent_q[2][1];
        entry_c2_o = ent_q[2][2];
        entry_c3_o = ent_q[2][3];
      end
    endcase
  end

  assign out_valid_o  = ser_v_q;
  assign row_index_o  = cnt_q;
  assign last_row_o   = (cnt_q == ROW_Z);
  assign degenerate_o = dg_q;

endmodule

/* sv/lvm_check.sv */
// port checker for the look-at view matrix block, bound to the top level
module lvm_check import lvm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        row_index_o,
  input logic [CoordW-1:0] entry_c0_o,
  input logic [CoordW-1:0] entry_c1_o,
  input logic [CoordW-1:0] entry_c2_o,
  input logic [CoordW-1:0] entry_c3_o,
  input logic              last_row_o,
  input logic              degenerate_o
);

  // last flag marks exactly the z row
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_row_o == (row_index_o == ROW_Z)))
    else $error("last_row does not match row_index");

  // rows of one matrix come in order without gaps in the word stream
  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && row_index_o == ROW_X)
      |=> (out_valid_o && row_index_o == ROW_Y))
    else $error("row x not followed by row y");

  a_row_seq2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && row_index_o == ROW_Y)
      |=> (out_valid_o && row_index_o == ROW_Z))
    else $error("row y not followed by row z");

  // degenerate matrices carry all-zero rows
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o)
      |-> (entry_c0_o == '0 && entry_c1_o == '0 && entry_c2_o == '0 && entry_c3_o == '0))
    else $error("degenerate row with nonzero entries");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i)
      |=> (out_valid_o && $stable(row_index_o) && $stable(entry_c3_o)))
    else $error("stalled output word changed");

endmodule

bind lookat_view_matrix_top lvm_check u_lvm_check (.*);
